[rtl/core/kvls_pkg.sv]
`default_nettype none
package kvls_pkg;

  localparam int PAGE_ENTRIES = 256;
  localparam int IDX_W = $clog2(PAGE_ENTRIES);
  localparam int PTR_W = IDX_W + 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam int ENTRY_W = 64;

  localparam logic [31:0] ERASED_KEY = 32'hFFFF_FFFF;
  localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(PAGE_ENTRIES);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(PAGE_ENTRIES - 1);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_req;
    logic rd_init;
    logic rd_issue;
    logic set_found;
    logic set_notfound;
    logic set_full;
    logic wr_entry;
    logic cp_init;
    logic src_issue;
    logic src_latch;
    logic dst_init;
    logic dst_issue;
    logic dst_write;
    logic cp_finish;
    logic clear;
    logic out_load;
  } kvls_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic key_erased;
    logic wp_zero;
    logic wp_full;
    logic wp_last;
    logic idx_zero;
    logic rd_match;
    logic ent_erased;
    logic j_eq_cnt;
    logic cnt_full;
    logic dst_match;
    logic out_free;
  } kvls_sts_t;

endpackage
`default_nettype wire

[rtl/core/kvls_if.sv]
`default_nettype none
interface kvls_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] key;
  logic [31:0] write_value;
  modport source (output valid, output cmd, output key, output write_value, input ready);
  modport sink (input valid, input cmd, input key, input write_value, output ready);
endinterface

interface kvls_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] read_value;
  logic        compacted;
  modport source (output valid, output status, output read_value, output compacted,
                  input ready);
  modport sink (input valid, input status, input read_value, input compacted,
                output ready);
endinterface
`default_nettype wire

[rtl/core/kvls_ram.sv]
`default_nettype none
module kvls_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[rtl/core/kvls_datapath.sv]
`default_nettype none
module kvls_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire kvls_pkg::kvls_ctl_t ctl,
  output kvls_pkg::kvls_sts_t      sts,
  kvls_req_if.sink                 in_req,
  kvls_rsp_if.source               out_rsp
);

  logic [1:0]                 cmd_r;
  logic [31:0]                key_r;
  logic [31:0]                val_r;
  logic [kvls_pkg::PTR_W-1:0] wp_r;
  logic                       act_r;
  logic [kvls_pkg::PTR_W-1:0] idx_r;
  logic [kvls_pkg::PTR_W-1:0] cnt_r;
  logic [kvls_pkg::PTR_W-1:0] j_r;
  logic [kvls_pkg::ENTRY_W-1:0] ent_r;
  logic [1:0]                 st_r;
  logic [31:0]                rv_r;
  logic                       cp_r;
  logic                       ov_r;
  logic [1:0]                 ost_r;
  logic [31:0]                orv_r;
  logic                       ocp_r;

  logic [kvls_pkg::PTR_W-1:0]   idx_m1;
  logic [kvls_pkg::ADDR_W-1:0]  ram_addr;
  logic                         ram_we;
  logic [kvls_pkg::ENTRY_W-1:0] ram_wdata;
  logic [kvls_pkg::ENTRY_W-1:0] ram_rdata;
  logic [31:0]                  rd_key;

  assign idx_m1 = idx_r - 1'b1;
  assign rd_key = ram_rdata[31:0];

  // select memory address and write data
  always_comb begin
    ram_addr  = {act_r, idx_m1[kvls_pkg::IDX_W-1:0]};
    ram_we    = 1'b0;
    ram_wdata = {val_r, key_r};
    if (ctl.wr_entry) begin
      ram_addr = {act_r, wp_r[kvls_pkg::IDX_W-1:0]};
      ram_we   = 1'b1;
    end else if (ctl.dst_write) begin
      ram_addr  = {~act_r, cnt_r[kvls_pkg::IDX_W-1:0]};
      ram_we    = 1'b1;
      ram_wdata = ent_r;
    end else if (ctl.dst_issue) begin
      ram_addr = {~act_r, j_r[kvls_pkg::IDX_W-1:0]};
    end
  end

  kvls_ram #(
    .WIDTH(kvls_pkg::ENTRY_W),
    .DEPTH(2 * kvls_pkg::PAGE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // status toward the controller
  always_comb begin
    sts.cmd        = kvls_pkg::cmd_t'(cmd_r);
    sts.key_erased = (key_r == kvls_pkg::ERASED_KEY);
    sts.wp_zero    = (wp_r == '0);
    sts.wp_full    = (wp_r == kvls_pkg::PTR_FULL);
    sts.wp_last    = (wp_r == kvls_pkg::PTR_LAST);
    sts.idx_zero   = (idx_r == '0);
    sts.rd_match   = (rd_key == key_r);
    sts.ent_erased = (rd_key == kvls_pkg::ERASED_KEY);
    sts.j_eq_cnt   = (j_r == cnt_r);
    sts.cnt_full   = (cnt_r == kvls_pkg::PTR_FULL);
    sts.dst_match  = (rd_key == ent_r[31:0]);
    sts.out_free   = !ov_r || out_rsp.ready;
  end

  // control state: page, pointer, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      act_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      if (ctl.clear) begin
        wp_r  <= '0;
        act_r <= 1'b0;
      end else if (ctl.cp_finish) begin
        wp_r  <= cnt_r;
        act_r <= ~act_r;
      end else if (ctl.wr_entry) begin
        wp_r <= wp_r + 1'b1;
      end
      if (ctl.out_load) begin
        ov_r <= 1'b1;
      end else if (out_rsp.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // request, scan counters and result
  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      cmd_r <= in_req.cmd;
      key_r <= in_req.key;
      val_r <= in_req.write_value;
      st_r  <= kvls_pkg::ST_OK;
      rv_r  <= '0;
      cp_r  <= 1'b0;
    end
    if (ctl.rd_init) begin
      idx_r <= wp_r;
    end else if (ctl.cp_init) begin
      idx_r <= kvls_pkg::PTR_FULL;
    end else if (ctl.rd_issue || ctl.src_issue) begin
      idx_r <= idx_m1;
    end
    if (ctl.cp_init) begin
      cnt_r <= '0;
      cp_r  <= 1'b1;
    end else if (ctl.dst_write) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (ctl.dst_init) begin
      j_r <= '0;
    end else if (ctl.dst_issue) begin
      j_r <= j_r + 1'b1;
    end
    if (ctl.src_latch) begin
      ent_r <= ram_rdata;
    end
    if (ctl.set_found) begin
      rv_r <= ram_rdata[63:32];
    end
    if (ctl.set_notfound) begin
      st_r <= kvls_pkg::ST_NOT_FOUND;
    end
    if (ctl.set_full) begin
      st_r <= kvls_pkg::ST_FULL;
    end
    if (ctl.out_load) begin
      ost_r <= st_r;
      orv_r <= rv_r;
      ocp_r <= cp_r;
    end
  end

  assign out_rsp.valid      = ov_r;
  assign out_rsp.status     = ost_r;
  assign out_rsp.read_value = orv_r;
  assign out_rsp.compacted  = ocp_r;

endmodule
`default_nettype wire

[rtl/core/kvls_ctrl.sv]
`default_nettype none
module kvls_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire kvls_pkg::kvls_sts_t sts,
  output kvls_pkg::kvls_ctl_t      ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_ISSUE,
    S_RD_CHECK,
    S_CP_SRC_RD,
    S_CP_SRC_CHK,
    S_CP_DST_RD,
    S_CP_DST_CHK,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // decode state into datapath commands
  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_req = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.cmd)
          kvls_pkg::CMD_WRITE: begin
            if (sts.wp_full) begin
              ctl.set_full = 1'b1;
              state_nxt    = S_FIN;
            end else begin
              ctl.wr_entry = 1'b1;
              if (sts.wp_last) begin
                ctl.cp_init = 1'b1;
                state_nxt   = S_CP_SRC_RD;
              end else begin
                state_nxt = S_FIN;
              end
            end
          end
          kvls_pkg::CMD_READ: begin
            if (sts.key_erased || sts.wp_zero) begin
              ctl.set_notfound = 1'b1;
              state_nxt        = S_FIN;
            end else begin
              ctl.rd_init = 1'b1;
              state_nxt   = S_RD_ISSUE;
            end
          end
          kvls_pkg::CMD_CLEAR: begin
            ctl.clear = 1'b1;
            state_nxt = S_FIN;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_RD_ISSUE: begin
        ctl.rd_issue = 1'b1;
        state_nxt    = S_RD_CHECK;
      end
      S_RD_CHECK: begin
        if (sts.rd_match) begin
          ctl.set_found = 1'b1;
          state_nxt     = S_FIN;
        end else if (sts.idx_zero) begin
          ctl.set_notfound = 1'b1;
          state_nxt        = S_FIN;
        end else begin
          state_nxt = S_RD_ISSUE;
        end
      end
      S_CP_SRC_RD: begin
        if (sts.idx_zero) begin
          ctl.cp_finish = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          ctl.src_issue = 1'b1;
          state_nxt     = S_CP_SRC_CHK;
        end
      end
      S_CP_SRC_CHK: begin
        if (sts.ent_erased) begin
          state_nxt = S_CP_SRC_RD;
        end else begin
          ctl.src_latch = 1'b1;
          ctl.dst_init  = 1'b1;
          state_nxt     = S_CP_DST_RD;
        end
      end
      S_CP_DST_RD: begin
        if (sts.j_eq_cnt) begin
          ctl.dst_write = !sts.cnt_full;
          state_nxt     = S_CP_SRC_RD;
        end else begin
          ctl.dst_issue = 1'b1;
          state_nxt     = S_CP_DST_CHK;
        end
      end
      S_CP_DST_CHK: begin
        state_nxt = sts.dst_match ? S_CP_SRC_RD : S_CP_DST_RD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/two_page_kv_log_store_top.sv]
`default_nettype none
// channel   dir  payload                            handshake
// in_req    in   cmd[1:0] key[31:0] write_value     valid/ready
// out_rsp   out  status[1:0] read_value compacted   valid/ready
//
// One request at a time. A read scans the log from the newest entry back,
// one entry at a time through the single-port log memory.
// A write that fills the page runs compaction: each non-erased source entry,
// newest first, is checked against the entries already copied and is copied
// into the other page only if its key is not there yet.
// Reset is synchronous and needs no clearing pass: the write pointer bounds
// every scan. A stalled result holds while the next request is taken in.
module two_page_kv_log_store_top (
  input wire logic   clk,
  input wire logic   rst_n,
  kvls_req_if.sink   in_req,
  kvls_rsp_if.source out_rsp
);

  kvls_pkg::kvls_ctl_t ctl;
  kvls_pkg::kvls_sts_t sts;

  kvls_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_req.valid),
    .in_ready(in_req.ready),
    .sts     (sts),
    .ctl     (ctl)
  );

  kvls_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sts    (sts),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

endmodule
`default_nettype wire
